// ===== rtl/tsr_pkg.sv =====
package tsr_pkg;

    localparam int REG_WORDS = 128;
    localparam int CHANNELS  = 16;

    localparam int REG_AW = (REG_WORDS > 1) ? $clog2(REG_WORDS) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int WIDX_W = 7;
    localparam int ECH_W  = 5;
    localparam int CNT_W  = 16;

    // special register words
    localparam logic [WIDX_W-1:0] W_CONFIG = 7'd0;
    localparam logic [WIDX_W-1:0] W_GENCS  = 7'd2;
    localparam logic [WIDX_W-1:0] W_DATA   = 7'd64;

    // field positions
    localparam int CFG_CH_LSB = 1;
    localparam int CFG_CH_MSB = 5;
    localparam int GEN_STM    = 3;
    localparam int GEN_EN     = 5;
    localparam int GEN_SWTS   = 7;
    localparam int DAT_EOS    = 27;
    localparam int DAT_OVR    = 29;
    localparam int DAT_RNG    = 30;

    localparam logic [31:0] DAT_W1C_MASK =
        (32'd1 << DAT_EOS) | (32'd1 << DAT_OVR) | (32'd1 << DAT_RNG);
    localparam logic [CNT_W-1:0] COUNT_DEFAULT = 16'h0100;
    localparam logic [31:0]      GENCS_INIT    = 32'h0200_1000;

    typedef enum logic [1:0] {
        OP_READ      = 2'd0,
        OP_WRITE     = 2'd1,
        OP_TRIGGER   = 2'd2,
        OP_SET_COUNT = 2'd3
    } t_op;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    // reset value of a register word held in the memory
    function automatic logic [31:0] init_word(input logic [REG_AW-1:0] a);
        logic [31:0] v;
        unique case (int'(a))
            2:       v = GENCS_INIT;
            4:       v = 32'h0007_0001;
            5:       v = 32'h6032_0000;
            6:       v = 32'h0060_0040;
            7:       v = 32'h1008_0101;
            8:       v = 32'h0001_0000;
            10:      v = 32'h0400_0000;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/tsr_ctrl.sv =====
module tsr_ctrl import tsr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    always_comb begin
        w_slot_free    = !r_out_valid || i_out_ready;
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.commit   = (r_state == S_EXEC) && w_slot_free;
        o_in_ready     = (r_state == S_IDLE);
        o_out_valid    = r_out_valid;

        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (o_cmd.capture) n_state = S_EXEC;
            S_EXEC: if (o_cmd.commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase

        n_out_valid = o_cmd.commit || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.commit))
        else $error("capture and commit in the same cycle");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("committed item not presented");

    a_busy_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_in_ready)
        else $error("accepted a new item while one is in work");

    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_cmd.commit)
        else $error("commit over a result still waiting");

endmodule

// ===== rtl/tsr_dp.sv =====
module tsr_dp import tsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [1:0]        i_op,
    input  logic [WIDX_W-1:0] i_word_index,
    input  logic [31:0]       i_write_data,
    input  logic              i_trigger_level,
    input  logic [ECH_W-1:0]  i_electrode_channel,
    input  logic [CNT_W-1:0]  i_electrode_value,
    output logic [31:0]       o_read_data,
    output logic              o_irq_level
);

    // captured item
    t_op               r_op;
    logic [WIDX_W-1:0] r_idx;
    logic [31:0]       r_wdata;
    logic              r_lvl;
    logic [ECH_W-1:0]  r_ech;
    logic [CNT_W-1:0]  r_eval;

    // register file memory, words other than config, gencs and data
    logic [31:0]          r_mem [REG_WORDS];
    logic [REG_WORDS-1:0] r_mem_vld;
    logic [31:0]          r_mem_q;
    logic                 r_mem_hit;
    logic [31:0]          r_mem_init;

    logic [31:0]      r_cfg_word, n_cfg_word;
    logic [31:0]      r_gencs, n_gencs;
    logic [31:0]      r_data, n_data;
    logic [CNT_W-1:0] r_counts [CHANNELS];

    logic [REG_AW-1:0]  w_rd_addr, w_wr_addr;
    logic               w_in_range, w_mem_we, w_cnt_we, w_scan;
    logic [31:0]        w_mem_word, w_rd;
    logic [4:0]         w_cfg_ch;
    logic [CH_W-1:0]    w_sel, w_ech;
    logic [CNT_W-1:0]   w_count;

    always_comb begin
        w_rd_addr  = REG_AW'(i_word_index);
        w_wr_addr  = REG_AW'(r_idx);
        w_in_range = 32'(r_idx) < 32'(REG_WORDS);
        w_mem_word = r_mem_hit ? r_mem_q : r_mem_init;

        w_cfg_ch = r_cfg_word[CFG_CH_MSB:CFG_CH_LSB];
        w_sel    = (32'(w_cfg_ch) < 32'(CHANNELS)) ? CH_W'(w_cfg_ch) : '0;
        w_count  = r_counts[w_sel];
        w_ech    = CH_W'(r_ech);

        n_cfg_word = r_cfg_word;
        n_gencs    = r_gencs;
        n_data     = r_data;
        w_rd       = 32'd0;
        w_mem_we   = 1'b0;
        w_cnt_we   = 1'b0;
        w_scan     = 1'b0;

        unique case (r_op)
            OP_READ: begin
                if (r_idx == W_CONFIG) begin
                    w_rd = r_cfg_word;
                end else if (r_idx == W_GENCS) begin
                    w_rd = r_gencs & ~(32'd1 << GEN_SWTS);
                end else if (r_idx == W_DATA) begin
                    w_rd = r_data;
                end else if (w_in_range) begin
                    w_rd = w_mem_word;
                end
            end
            OP_WRITE: begin
                if (r_idx == W_GENCS) begin
                    n_gencs = r_wdata & ~(32'd1 << GEN_SWTS);
                    w_scan  = r_wdata[GEN_SWTS] && r_wdata[GEN_EN];
                end else if (r_idx == W_DATA) begin
                    n_data = r_data & ~(r_wdata & DAT_W1C_MASK);
                end else if (r_idx == W_CONFIG) begin
                    n_cfg_word = r_wdata;
                end else if (w_in_range) begin
                    w_mem_we = 1'b1;
                end
            end
            OP_TRIGGER: begin
                w_scan = r_lvl && r_gencs[GEN_STM] && r_gencs[GEN_EN];
            end
            OP_SET_COUNT: begin
                w_cnt_we = 32'(r_ech) < 32'(CHANNELS);
            end
            default: ;
        endcase

        if (w_scan) begin
            n_data = {r_data[31:CNT_W], w_count} | (32'd1 << DAT_EOS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= t_op'(i_op);
            r_idx      <= i_word_index;
            r_wdata    <= i_write_data;
            r_lvl      <= i_trigger_level;
            r_ech      <= i_electrode_channel;
            r_eval     <= i_electrode_value;
            r_mem_q    <= r_mem[w_rd_addr];
            r_mem_hit  <= r_mem_vld[w_rd_addr];
            r_mem_init <= init_word(w_rd_addr);
        end
        if (i_cmd.commit && w_mem_we) begin
            r_mem[w_wr_addr] <= r_wdata;
        end
        if (i_cmd.commit) begin
            o_read_data <= w_rd;
            o_irq_level <= n_gencs[GEN_EN] && n_data[DAT_EOS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld  <= '0;
            r_cfg_word <= 32'd0;
            r_gencs    <= GENCS_INIT;
            r_data     <= 32'd0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_counts[i] <= COUNT_DEFAULT;
            end
        end else if (i_cmd.commit) begin
            r_cfg_word <= n_cfg_word;
            r_gencs    <= n_gencs;
            r_data     <= n_data;
            if (w_mem_we) begin
                r_mem_vld[w_wr_addr] <= 1'b1;
            end
            if (w_cnt_we) begin
                r_counts[w_ech] <= r_eval;
            end
        end
    end

    a_swts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_gencs[GEN_SWTS])
        else $error("software trigger bit stored");

    a_scan_sets_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_scan) |=> r_data[DAT_EOS])
        else $error("scan did not set end of scan");

    a_irq_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (o_irq_level == (r_gencs[GEN_EN] && r_data[DAT_EOS])))
        else $error("interrupt level disagrees with registers");

endmodule

// ===== rtl/touch_sense_register_block.sv =====
// channel  | handshake                  | payload
// item in  | i_in_valid / o_in_ready    | i_op, i_word_index, i_write_data,
//          |                            | i_trigger_level, i_electrode_channel,
//          |                            | i_electrode_value
// item out | o_out_valid / i_out_ready  | o_read_data, o_irq_level
//
// each item is accepted, then committed once the output register is free;
// the registered read port of the register-file memory keeps the two steps apart
// one item in work at a time; a stalled output holds the commit, not the result
// synchronous active-low reset; register words come back from per-word valid
// bits and the reset table, electrode counts are cleared to their default at once
module touch_sense_register_block import tsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_op,
    input  logic [WIDX_W-1:0] i_word_index,
    input  logic [31:0]       i_write_data,
    input  logic              i_trigger_level,
    input  logic [ECH_W-1:0]  i_electrode_channel,
    input  logic [CNT_W-1:0]  i_electrode_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [31:0]       o_read_data,
    output logic              o_irq_level
);

    t_cmd w_cmd;

    tsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    tsr_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_op                (i_op),
        .i_word_index        (i_word_index),
        .i_write_data        (i_write_data),
        .i_trigger_level     (i_trigger_level),
        .i_electrode_channel (i_electrode_channel),
        .i_electrode_value   (i_electrode_value),
        .o_read_data         (o_read_data),
        .o_irq_level         (o_irq_level)
    );

endmodule
